// File: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_INIT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_item_t;

endpackage

// File: hw/rtl/tcw_screen_mem.sv
module tcw_screen_mem #(
  parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data
);

  logic [15:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_q[rd_addr];
    end
  end

endmodule

// File: hw/rtl/tcw_ctrl.sv
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int AW      = $clog2(CELLS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               res_valid,
  input  logic               res_ready,
  output tcw_pkg::out_item_t res,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr,
  input  logic [15:0]        mem_rd_data,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [15:0]        mem_wr_data
);

  import tcw_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CLW = $clog2(COLUMNS);
  localparam int CW = $clog2(CELLS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RESP   = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_FILL   = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [7:0]     attr_r, attr_nxt;
  logic           boot_r, boot_nxt;
  logic [CW-1:0]  sweep_r, sweep_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  dst_r, dst_nxt;
  logic           rd_ok_r, rd_ok_nxt;

  logic           nl_req;
  logic           rd_in_range;
  logic [AW-1:0]  put_addr;
  logic [AW-1:0]  read_addr;
  logic [7:0]     fill_attr;

  assign put_addr  = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign rd_in_range = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLUMNS);
  assign read_addr = AW'(in_data.read_row) * AW'(COLUMNS) + AW'(in_data.read_col);
  // the pass after reset blanks with the reset colour whatever config does meanwhile
  assign fill_attr = boot_r ? RESET_ATTR : attr_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res.cell_value = rd_ok_r ? mem_rd_data : 16'd0;
  assign res.cursor_row = 5'(row_r);
  assign res.cursor_col = 7'(col_r);

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    attr_nxt    = cfg_wr_en ? cfg_wr_data : attr_r;
    boot_nxt    = boot_r;
    sweep_nxt   = sweep_r;
    pend_nxt    = 1'b0;
    dst_nxt     = dst_r;
    rd_ok_nxt   = rd_ok_r;
    nl_req      = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = sweep_r[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = dst_r;
    mem_wr_data = mem_rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RESP;
          rd_ok_nxt = 1'b0;
          unique case (in_data.command)
            CMD_PUT: begin
              if (in_data.char_code == CH_LF || in_data.char_code == CH_CR) begin
                nl_req = 1'b1;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = put_addr;
                mem_wr_data = {attr_r, in_data.char_code};
                if (col_r == CLW'(COLUMNS - 1)) begin
                  nl_req = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
            end
            CMD_START: begin
              nl_req = (col_r != '0);
            end
            CMD_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = ST_FILL;
            end
            CMD_INIT: begin
              row_nxt   = '0;
              col_nxt   = '0;
              sweep_nxt = '0;
              state_nxt = ST_FILL;
            end
            CMD_READ: begin
              rd_ok_nxt   = rd_in_range;
              mem_rd_en   = rd_in_range;
              mem_rd_addr = read_addr;
            end
            default: ;
          endcase
          if (nl_req) begin
            col_nxt = '0;
            if (row_r == RW'(ROWS - 1)) begin
              sweep_nxt = CW'(COLUMNS);
              state_nxt = ST_SCROLL;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
        end
      end
      ST_SCROLL: begin
        // read one row below, write back the word from the previous read
        if (sweep_r != CW'(CELLS)) begin
          mem_rd_en = 1'b1;
          pend_nxt  = 1'b1;
          dst_nxt   = AW'(sweep_r - CW'(COLUMNS));
          sweep_nxt = sweep_r + 1'b1;
        end else begin
          sweep_nxt = CW'(CELLS - COLUMNS);
          state_nxt = ST_FILL;
        end
        if (pend_r) begin
          mem_wr_en = 1'b1;
        end
      end
      ST_FILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sweep_r[AW-1:0];
        mem_wr_data = {fill_attr, BLANK_CHAR};
        sweep_nxt   = sweep_r + 1'b1;
        if (sweep_r == CW'(CELLS - 1)) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? ST_IDLE : ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      row_r   <= '0;
      col_r   <= '0;
      attr_r  <= RESET_ATTR;
      boot_r  <= 1'b1;
      sweep_r <= '0;
      pend_r  <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      attr_r  <= attr_nxt;
      boot_r  <= boot_nxt;
      sweep_r <= sweep_nxt;
      pend_r  <= pend_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r <= dst_nxt;
  end

endmodule

// File: hw/rtl/text_console_writer_top.sv
// channel  direction  word         handshake
// in_      input      in_item_t    in_valid / in_stall
// out_     output     out_item_t   out_valid / out_stall
// cfg_     input      attribute    cfg_wr_en, no wait
//
// Put, start line, read and unused commands: accept, then result, unless a new line scrolls.
// A new line on the bottom row scrolls through the screen store, one cell a cycle
// on its single write port, then blanks the bottom row. Clear and init blank every cell.
// After reset a blanking pass over all ROWS*COLUMNS cells runs with in_stall high.
// The output register frees the block to take the next word while a result is stalled.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);

  logic          res_valid;
  logic          res_ready;
  out_item_t     res;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [15:0]   mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [15:0]   mem_wr_data;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the input stalls in the cycle after every word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on consecutive cycles");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid)
    else $error("result lost on the way to the output register");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && in_stall))
    else $error("pending result dropped");

  a_no_result_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !res_valid)
    else $error("result pending while input open");

endmodule
